// ===== hw/rtl/sync_framed_packet_extractor_top_defines.svh =====
// Assertion macros shared by the RTL files of the frame extractor.
`ifndef SYNC_FRAMED_PACKET_EXTRACTOR_TOP_DEFINES_SVH
`define SYNC_FRAMED_PACKET_EXTRACTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFPE_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfpe: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfpe: next-cycle check failed");

`endif

// ===== hw/rtl/sfpe_pkg.sv =====
`timescale 1ns / 1ps

package sfpe_pkg;

  localparam int unsigned HEAD_BYTES_DEF = 2;
  localparam int unsigned TAIL_BYTES_DEF = 2;
  localparam int unsigned MAX_BUFFER_DEF = 65536;

  localparam int unsigned LEN_W     = 16;
  localparam int unsigned PAT_W     = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_PATTERN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_PATTERN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SHORT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_HEAD       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TAIL_BEYOND   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TAIL_MISMATCH = 3'd4;

  typedef struct packed {
    logic             sync_mode;
    logic [PAT_W-1:0] head_pattern;
    logic [PAT_W-1:0] tail_pattern;
    logic [LEN_W-1:0] payload_length;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    payload_offset;
    logic [LEN_W-1:0]    payload_size;
  } res_t;

endpackage

// ===== hw/rtl/sfpe_tracker.sv =====
`timescale 1ns / 1ps

`include "sync_framed_packet_extractor_top_defines.svh"

module sfpe_tracker #(
  parameter int unsigned HEAD_BYTES = sfpe_pkg::HEAD_BYTES_DEF,
  parameter int unsigned TAIL_BYTES = sfpe_pkg::TAIL_BYTES_DEF,
  parameter int unsigned MAX_BUFFER = sfpe_pkg::MAX_BUFFER_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  logic [7:0]     data_byte,
  input  logic           buffer_end,
  input  sfpe_pkg::cfg_t cfg,
  output sfpe_pkg::res_t res
);
  import sfpe_pkg::*;

  localparam int unsigned HW    = 8 * HEAD_BYTES;
  localparam int unsigned TW    = 8 * TAIL_BYTES;
  localparam int unsigned CNT_W = $clog2(MAX_BUFFER + 1);
  localparam int unsigned SUM_W = (CNT_W > LEN_W + 1) ? CNT_W : LEN_W + 1;
  localparam int unsigned TI_W  = (TAIL_BYTES > 1) ? $clog2(TAIL_BYTES) : 1;

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_TAIL   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [HW-1:0]    window_r, window_nxt, win_upd;
  logic [CNT_W-1:0] bytes_seen_r, bytes_seen_nxt, cnt_upd;
  logic [1:0]       phase_r, phase_nxt, ph_upd;
  logic [LEN_W-1:0] phase_count_r, phase_count_nxt, pc_upd;
  logic [CNT_W-1:0] payload_start_r, payload_start_nxt, start_upd;
  logic             mismatch_r, mismatch_nxt, mis_upd;

  logic [HW-1:0]    head_ext;
  logic [TW-1:0]    tail_ext;
  logic [TI_W-1:0]  tail_sel;
  logic [7:0]       tail_want;
  logic [SUM_W-1:0] frame_min;
  logic [SUM_W-1:0] cnt_ext;
  logic [STATUS_W-1:0] st;

  // Patterns widened to the window size; bytes above the register are zero.
  for (genvar i = 0; i < HW; i++) begin : g_head
    if (i < PAT_W) begin : g_in
      assign head_ext[i] = cfg.head_pattern[i];
    end else begin : g_zero
      assign head_ext[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < TW; i++) begin : g_tail
    if (i < PAT_W) begin : g_in
      assign tail_ext[i] = cfg.tail_pattern[i];
    end else begin : g_zero
      assign tail_ext[i] = 1'b0;
    end
  end

  // first tail byte sits in the top byte
  assign tail_sel  = TI_W'(TAIL_BYTES - 1) - phase_count_r[TI_W-1:0];
  assign tail_want = 8'(tail_ext >> {tail_sel, 3'b000});

  always_comb begin
    win_upd   = window_r;
    cnt_upd   = bytes_seen_r;
    ph_upd    = phase_r;
    pc_upd    = phase_count_r;
    start_upd = payload_start_r;
    mis_upd   = mismatch_r;
    if (bytes_seen_r < CNT_W'(MAX_BUFFER)) begin
      cnt_upd = bytes_seen_r + 1'b1;
      win_upd = HW'({window_r, data_byte});
      case (phase_r)
        PH_SEARCH: begin
          if (cnt_upd >= CNT_W'(HEAD_BYTES) && win_upd == head_ext) begin
            start_upd = cnt_upd;
            if (cfg.payload_length == '0) begin
              ph_upd = PH_TAIL;
              pc_upd = '0;
            end else begin
              ph_upd = PH_SKIP;
              pc_upd = cfg.payload_length;
            end
          end
        end
        PH_SKIP: begin
          pc_upd = phase_count_r - 1'b1;
          if (pc_upd == '0) ph_upd = PH_TAIL;
        end
        PH_TAIL: begin
          if (tail_want != data_byte) mis_upd = 1'b1;
          pc_upd = phase_count_r + 1'b1;
          if (phase_count_r == LEN_W'(TAIL_BYTES - 1)) ph_upd = PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // Verdict for a buffer ending on this byte.
  assign frame_min = SUM_W'(cfg.payload_length) + SUM_W'(HEAD_BYTES + TAIL_BYTES);
  assign cnt_ext   = SUM_W'(cnt_upd);

  always_comb begin
    if (!cfg.sync_mode) begin
      st = (cnt_ext >= SUM_W'(cfg.payload_length)) ? ST_OK : ST_TOO_SHORT;
    end else if (cnt_ext < frame_min) begin
      st = ST_TOO_SHORT;
    end else if (ph_upd == PH_SEARCH) begin
      st = ST_NO_HEAD;
    end else if (ph_upd != PH_DONE) begin
      st = ST_TAIL_BEYOND;
    end else begin
      st = mis_upd ? ST_TAIL_MISMATCH : ST_OK;
    end
    res.status         = st;
    res.payload_offset = (st == ST_OK && cfg.sync_mode) ? LEN_W'(start_upd) : '0;
    res.payload_size   = (st == ST_OK) ? cfg.payload_length : '0;
  end

  always_comb begin
    if (buffer_end) begin
      window_nxt        = '0;
      bytes_seen_nxt    = '0;
      phase_nxt         = PH_SEARCH;
      phase_count_nxt   = '0;
      payload_start_nxt = '0;
      mismatch_nxt      = 1'b0;
    end else begin
      window_nxt        = win_upd;
      bytes_seen_nxt    = cnt_upd;
      phase_nxt         = ph_upd;
      phase_count_nxt   = pc_upd;
      payload_start_nxt = start_upd;
      mismatch_nxt      = mis_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r        <= '0;
      bytes_seen_r    <= '0;
      phase_r         <= PH_SEARCH;
      phase_count_r   <= '0;
      payload_start_r <= '0;
      mismatch_r      <= 1'b0;
    end else if (take) begin
      window_r        <= window_nxt;
      bytes_seen_r    <= bytes_seen_nxt;
      phase_r         <= phase_nxt;
      phase_count_r   <= phase_count_nxt;
      payload_start_r <= payload_start_nxt;
      mismatch_r      <= mismatch_nxt;
    end
  end

  `SFPE_ASSERT_NEXT(a_end_clears, clk, rst_n, take && buffer_end, bytes_seen_r == '0 && phase_r == PH_SEARCH)
  `SFPE_ASSERT_HOLD(a_cnt_bound, clk, rst_n, 1'b1, bytes_seen_r <= CNT_W'(MAX_BUFFER))
  `SFPE_ASSERT_HOLD(a_head_seen, clk, rst_n, phase_r != PH_SEARCH, bytes_seen_r >= CNT_W'(HEAD_BYTES))

endmodule

// ===== hw/rtl/sync_framed_packet_extractor_top.sv =====
// Latency: a status appears on out_* the cycle after the last byte of a buffer is accepted.
// Throughput: one byte per cycle while in_stall is low; the byte tracker computes its next state combinationally.
// A single output register decouples the sides; input stalls only while it is full and stalled.
// Reset (rst_n low, synchronous): sync_mode=1, patterns=0, payload_length=256, buffer state
// cleared, no status pending. No clearing pass; bytes are accepted right after reset.
`timescale 1ns / 1ps

`include "sync_framed_packet_extractor_top_defines.svh"

module sync_framed_packet_extractor_top #(
  parameter int unsigned HEAD_BYTES = sfpe_pkg::HEAD_BYTES_DEF,
  parameter int unsigned TAIL_BYTES = sfpe_pkg::TAIL_BYTES_DEF,
  parameter int unsigned MAX_BUFFER = sfpe_pkg::MAX_BUFFER_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write port
  input  logic                              cfg_we,
  input  logic [sfpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfpe_pkg::PAT_W-1:0]        cfg_data,
  // byte stream in
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_buffer_end,
  // status out
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sfpe_pkg::STATUS_W-1:0]     out_status,
  output logic [sfpe_pkg::LEN_W-1:0]        out_payload_offset,
  output logic [sfpe_pkg::LEN_W-1:0]        out_payload_size
);
  import sfpe_pkg::*;

  cfg_t cfg_r;
  res_t res;      // verdict for the byte being accepted
  res_t out_r;
  logic out_valid_r;
  logic in_acc;

  // Config registers; write them only while no buffer is in flight (the block itself does not enforce this).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_mode      <= 1'b1;
      cfg_r.head_pattern   <= '0;
      cfg_r.tail_pattern   <= '0;
      cfg_r.payload_length <= LEN_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_MODE:      cfg_r.sync_mode      <= cfg_data[0];
        REG_HEAD_PATTERN:   cfg_r.head_pattern   <= cfg_data;
        REG_TAIL_PATTERN:   cfg_r.tail_pattern   <= cfg_data;
        REG_PAYLOAD_LENGTH: cfg_r.payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off bytes only when a finished status cannot move on this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  sfpe_tracker #(
    .HEAD_BYTES(HEAD_BYTES),
    .TAIL_BYTES(TAIL_BYTES),
    .MAX_BUFFER(MAX_BUFFER)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (in_acc),
    .data_byte  (in_data_byte),
    .buffer_end (in_buffer_end),
    .cfg        (cfg_r),
    .res        (res)
  );

  // Output register: loaded on the last byte of a buffer, drained when the
  // downstream transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_buffer_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_buffer_end) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_payload_offset = out_r.payload_offset;
  assign out_payload_size   = out_r.payload_size;

  `SFPE_ASSERT_NEXT(a_end_gives_status, clk, rst_n, in_acc && in_buffer_end, out_valid_r)
  `SFPE_ASSERT_NEXT(a_drain, clk, rst_n, out_valid_r && !out_stall && !(in_acc && in_buffer_end), !out_valid_r)
  `SFPE_ASSERT_HOLD(a_fail_zero, clk, rst_n, out_valid_r && out_r.status != ST_OK, out_r.payload_offset == '0 && out_r.payload_size == '0)

endmodule

// ===== tb/sfpe_status_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own copy of the
// deframer state and checks every status transaction in order.
module sfpe_status_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfpe_pkg::PAT_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_buffer_end,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [sfpe_pkg::STATUS_W-1:0]  out_status,
  input  logic [sfpe_pkg::LEN_W-1:0]     out_payload_offset,
  input  logic [sfpe_pkg::LEN_W-1:0]     out_payload_size,
  output int                             mismatches,
  output int                             outstanding
);
  import sfpe_pkg::*;

  localparam int HB = HEAD_BYTES_DEF;
  localparam int TB = TAIL_BYTES_DEF;
  localparam int BUF_LIMIT = MAX_BUFFER_DEF;
  localparam logic [63:0] HEAD_MASK = (HB >= 8) ? {64{1'b1}} : (64'd1 << (8 * HB)) - 64'd1;

  typedef enum logic [1:0] {SCAN_HEAD, SCAN_BODY, SCAN_TAIL, SCAN_DONE} scan_e;

  cfg_t        regs;
  logic [63:0] window;     // newest byte in the low bits
  logic [16:0] seen;       // saturates at BUF_LIMIT
  scan_e       scan;
  logic [15:0] countdown;  // body bytes left, then tail bytes checked
  logic [16:0] body_at;
  logic        tail_bad;
  res_t        status_due[$];

  task automatic clear_scan();
    window    = '0;
    seen      = '0;
    scan      = SCAN_HEAD;
    countdown = '0;
    body_at   = '0;
    tail_bad  = 1'b0;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t       want;
    logic [7:0] tail_byte;
    int         tail_shift;
    if (!rst_n) begin
      regs.sync_mode      = 1'b1;
      regs.head_pattern   = '0;
      regs.tail_pattern   = '0;
      regs.payload_length = 16'd256;
      clear_scan();
      status_due.delete();
      mismatches  = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("status: unexpected transaction, status %0d offset %0d size %0d",
                 out_status, out_payload_offset, out_payload_size);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("payload_offset", want.payload_offset, out_payload_offset);
          compare_field("payload_size", want.payload_size, out_payload_size);
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_MODE:      regs.sync_mode      = cfg_data[0];
          REG_HEAD_PATTERN:   regs.head_pattern   = cfg_data;
          REG_TAIL_PATTERN:   regs.tail_pattern   = cfg_data;
          REG_PAYLOAD_LENGTH: regs.payload_length = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (seen < 17'(BUF_LIMIT)) begin
          seen++;
          window = ((window << 8) | 64'(in_data_byte)) & HEAD_MASK;
          case (scan)
            SCAN_HEAD:
              if (seen >= HB && window == (64'(regs.head_pattern) & HEAD_MASK)) begin
                body_at = seen;
                if (regs.payload_length == 0) begin
                  scan      = SCAN_TAIL;
                  countdown = '0;
                end else begin
                  scan      = SCAN_BODY;
                  countdown = regs.payload_length;
                end
              end
            SCAN_BODY: begin
              countdown--;
              if (countdown == 0) scan = SCAN_TAIL;
            end
            SCAN_TAIL: begin
              tail_shift = 8 * (TB - 1 - int'(countdown));
              tail_byte  = 8'(64'(regs.tail_pattern) >> tail_shift);
              if (tail_byte != in_data_byte) tail_bad = 1'b1;
              countdown++;
              if (countdown >= TB) scan = SCAN_DONE;
            end
            default: ;
          endcase
        end

        if (in_buffer_end) begin
          want.payload_offset = '0;
          want.payload_size   = '0;
          if (!regs.sync_mode)
            want.status = (seen >= regs.payload_length) ? ST_OK : ST_TOO_SHORT;
          else if (int'(seen) < int'(regs.payload_length) + HB + TB)
            want.status = ST_TOO_SHORT;
          else if (scan == SCAN_HEAD)
            want.status = ST_NO_HEAD;
          else if (scan != SCAN_DONE)
            want.status = ST_TAIL_BEYOND;
          else
            want.status = tail_bad ? ST_TAIL_MISMATCH : ST_OK;
          if (want.status == ST_OK) begin
            want.payload_offset = regs.sync_mode ? body_at[15:0] : '0;
            want.payload_size   = regs.payload_length;
          end
          status_due.push_back(want);
          clear_scan();
        end
      end
      outstanding <= status_due.size();
    end
  end

endmodule

// ===== tb/sync_framed_packet_extractor_top_test.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the sync-word deframer. The checker instance
// beside the block does all prediction and comparison.
module sync_framed_packet_extractor_top_test;
  import sfpe_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAT_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_data_byte;
  logic                 in_buffer_end;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  out_status;
  logic [LEN_W-1:0]     out_payload_offset;
  logic [LEN_W-1:0]     out_payload_size;

  int mismatches;
  int outstanding;

  // Percent chance per cycle that the sender holds off / the receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;

  // Host-side copy of the register settings, used only to shape frames.
  logic [15:0] cur_head;
  logic [15:0] cur_tail;
  logic [15:0] cur_len;

  // Bytes of the buffer being assembled.
  logic [7:0] frame[$];

  always #1 clk = ~clk;

  sync_framed_packet_extractor_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_buffer_end      (in_buffer_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_size   (out_payload_size)
  );

  sfpe_status_checker status_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_buffer_end      (in_buffer_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_size   (out_payload_size),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  // Receiver back-pressure, redrawn every cycle, independent of out_valid.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // One register write; the wait after lowering cfg_we keeps it from being lowered and
  // raised in the same step when writes come back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_HEAD_PATTERN:   cur_head = val;
      REG_TAIL_PATTERN:   cur_tail = val;
      REG_PAYLOAD_LENGTH: cur_len  = val;
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic mode, input logic [15:0] head,
                              input logic [15:0] tail, input logic [15:0] len);
    write_reg(REG_SYNC_MODE, {15'd0, mode});
    write_reg(REG_HEAD_PATTERN, head);
    write_reg(REG_TAIL_PATTERN, tail);
    write_reg(REG_PAYLOAD_LENGTH, len);
  endtask

  // Sender goes quiet until every status is back, then lets the output
  // register settle.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Push the assembled bytes through the handshake. With close set, the
  // last byte carries buffer_end.
  task automatic send_frame(input bit close);
    for (int i = 0; i < frame.size(); i++) begin
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid      <= 1'b1;
      in_data_byte  <= frame[i];
      in_buffer_end <= close && (i == frame.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    frame.delete();
  endtask

  task automatic add_word(input logic [15:0] w);
    frame.push_back(w[15:8]);
    frame.push_back(w[7:0]);
  endtask

  task automatic add_noise(input int n);
    repeat (n) frame.push_back(8'($urandom));
  endtask

  function automatic logic [15:0] pick_pattern();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_setting();
    logic [15:0] len;
    int          pick;
    pick = $urandom_range(19);
    if (pick < 13)      len = 16'($urandom_range(8));
    else if (pick < 19) len = 16'($urandom_range(9, 40));
    else                len = 16'd0;
    load_setting($urandom_range(7) != 0, pick_pattern(), pick_pattern(), len);
  endtask

  // Mostly head-and-tail frames with random content; some with a flipped tail
  // bit, some cut short anywhere, some plain noise.
  task automatic build_random_frame();
    int pick;
    int cut;
    pick = $urandom_range(99);
    if (pick < 85) begin
      add_noise($urandom_range(4));
      add_word(cur_head);
      add_noise(cur_len);
      if ($urandom_range(3) == 0) add_word(cur_tail ^ (16'd1 << $urandom_range(15)));
      else add_word(cur_tail);
      add_noise($urandom_range(3));
      if (pick >= 65) begin
        cut = $urandom_range(1, frame.size());
        while (frame.size() > cut) void'(frame.pop_back());
      end
    end else begin
      add_noise($urandom_range(1, cur_len + 6));
    end
  endtask

  // Random traffic; the setting is redrawn every handful of buffers, each
  // time after a full drain.
  task automatic random_phase(input int byte_budget);
    int sent;
    int left;
    sent = 0;
    left = 0;
    while (sent < byte_budget) begin
      if (left == 0) begin
        settle();
        random_setting();
        left = $urandom_range(6, 16);
      end
      build_random_frame();
      sent += frame.size();
      send_frame(1);
      left--;
    end
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 85, 0, 21};
    stall_tab = '{0, 0, 85, 21};

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_SYNC_MODE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_buffer_end = 1'b0;
    out_stall     = 1'b0;
    cur_head      = '0;
    cur_tail      = '0;
    cur_len       = 16'd256;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: zero head and tail, 256-byte payload.
    frame = '{8'h00, 8'h00, 8'h11};
    send_frame(1);
    add_word(16'h0000);
    add_noise(256);
    add_word(16'h0000);
    send_frame(1);
    settle();

    // All-ones head, all-zeros tail, 4-byte payload.
    load_setting(1'b1, 16'hFFFF, 16'h0000, 16'd4);
    frame = '{8'h01, 8'hFF, 8'hFF, 8'h10, 8'h20, 8'h30, 8'h40, 8'h00, 8'h00};
    send_frame(1);
    // tail mismatch on the last byte
    frame = '{8'hFF, 8'hFF, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'h00, 8'h01};
    send_frame(1);
    // buffer ends with only one tail byte in
    frame = '{8'h05, 8'h06, 8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00};
    send_frame(1);
    // long enough, no head anywhere
    frame = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
    send_frame(1);
    // head only half inside the buffer
    frame = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'hFF};
    send_frame(1);
    // head seen but buffer too short overall
    frame = '{8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03};
    send_frame(1);
    frame = '{8'h7E};
    send_frame(1);
    // bytes after the decision, another head among them, are ignored
    frame = '{8'hFF, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h55};
    send_frame(1);
    settle();

    // Zero payload: tail right after head.
    load_setting(1'b1, 16'h1234, 16'hABCD, 16'd0);
    frame = '{8'h12, 8'h34, 8'hAB, 8'hCD};
    send_frame(1);
    frame = '{8'h12, 8'h34, 8'hAB};
    send_frame(1);
    settle();

    // Mode flips halfway through a buffer; the mode at the last byte counts.
    write_reg(REG_PAYLOAD_LENGTH, 16'd4);
    frame = '{8'h01, 8'h02, 8'h03};
    send_frame(0);
    settle();
    write_reg(REG_SYNC_MODE, 16'd0);
    frame = '{8'h04, 8'h05, 8'h06};
    send_frame(1);
    frame = '{8'h12, 8'h34, 8'h01, 8'h02};
    send_frame(0);
    settle();
    write_reg(REG_SYNC_MODE, 16'd1);
    frame = '{8'h03, 8'h04, 8'hAB, 8'hCD};
    send_frame(1);
    settle();

    // Bypass: one byte short, then exactly one payload long.
    write_reg(REG_SYNC_MODE, 16'd0);
    frame = '{8'h07, 8'h07, 8'h07};
    send_frame(1);
    frame = '{8'hFF, 8'h00, 8'hFF, 8'h00};
    send_frame(1);
    settle();

    // Random traffic under each idle/stall mix.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      random_phase(150);
    end

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
